>>> sv/sem_pkg.sv
`timescale 1ns / 1ps
package sem_pkg;

    localparam int PIXEL_BITS  = 8;
    localparam int GRAD_BITS   = PIXEL_BITS + 3;
    localparam int ABS_BITS    = PIXEL_BITS + 2;
    localparam int ROOT_BITS   = PIXEL_BITS + 3;
    localparam int SQ_BITS     = 2 * ROOT_BITS;
    localparam int REM_BITS    = ROOT_BITS + 3;
    localparam int STEP_BITS   = $clog2(ROOT_BITS);
    localparam int CHANNELS    = 3;
    localparam int ROWS        = 3;
    localparam int COLS        = 3;
    localparam int TAPS        = ROWS * CHANNELS;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_BITS   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

    localparam int PRES_TOP    = 0;
    localparam int PRES_BOTTOM = 1;

    typedef logic [PIXEL_BITS-1:0] t_pix;
    typedef t_pix [TAPS-1:0]       t_column;

    localparam t_pix PIX_MAX = '1;

    typedef struct packed {
        t_column    left;
        t_column    mid;
        t_column    right;
        logic       has_left;
        logic       has_right;
        logic [1:0] pres;
        logic       last;
    } t_job;

    typedef struct packed {
        logic valid;
        t_job job;
    } t_push;

    typedef struct packed {
        logic valid;
        t_job job;
    } t_head;

endpackage

>>> sv/sem_stream_if.sv
`timescale 1ns / 1ps
interface sem_col_if;
    import sem_pkg::*;
    logic valid;
    logic ready;
    t_pix top_red;
    t_pix top_green;
    t_pix top_blue;
    t_pix mid_red;
    t_pix mid_green;
    t_pix mid_blue;
    t_pix bottom_red;
    t_pix bottom_green;
    t_pix bottom_blue;
    logic top_present;
    logic bottom_present;
    logic row_end;

    modport source (
        output valid, top_red, top_green, top_blue, mid_red, mid_green, mid_blue,
               bottom_red, bottom_green, bottom_blue, top_present, bottom_present,
               row_end,
        input  ready
    );
    modport sink (
        input  valid, top_red, top_green, top_blue, mid_red, mid_green, mid_blue,
               bottom_red, bottom_green, bottom_blue, top_present, bottom_present,
               row_end,
        output ready
    );
endinterface

interface sem_res_if;
    import sem_pkg::*;
    logic valid;
    logic ready;
    t_pix edge_red;
    t_pix edge_green;
    t_pix edge_blue;
    logic row_last;

    modport source (
        output valid, edge_red, edge_green, edge_blue, row_last,
        input  ready
    );
    modport sink (
        input  valid, edge_red, edge_green, edge_blue, row_last,
        output ready
    );
endinterface

>>> sv/sem_front.sv
`timescale 1ns / 1ps
module sem_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    sem_col_if.sink        i_col,
    input  logic           i_full,
    output sem_pkg::t_push o_push
);
    import sem_pkg::*;

    t_column    r_older, n_older;
    t_column    r_newer, n_newer;
    logic [1:0] r_pres, n_pres;
    logic [1:0] r_seen, n_seen;
    logic       r_pend, n_pend;

    t_column    w_cur;
    logic [1:0] w_cur_pres;
    logic       w_accept;

    assign w_cur = {i_col.bottom_blue, i_col.bottom_green, i_col.bottom_red,
                    i_col.mid_blue, i_col.mid_green, i_col.mid_red,
                    i_col.top_blue, i_col.top_green, i_col.top_red};
    assign w_cur_pres = {i_col.bottom_present, i_col.top_present};

    assign i_col.ready = !r_pend && !i_full;
    assign w_accept    = i_col.valid && i_col.ready;

    always_comb begin
        n_older = r_older;
        n_newer = r_newer;
        n_pres  = r_pres;
        n_seen  = r_seen;
        n_pend  = r_pend;
        o_push  = '0;
        if (r_pend) begin
            if (!i_full) begin
                o_push.valid         = 1'b1;
                o_push.job.left      = r_older;
                o_push.job.mid       = r_newer;
                o_push.job.has_left  = 1'b1;
                o_push.job.pres      = r_pres;
                o_push.job.last      = 1'b1;
                n_pend               = 1'b0;
            end
        end else if (w_accept) begin
            if (r_seen == 2'd0) begin
                n_newer = w_cur;
                n_pres  = w_cur_pres;
                if (i_col.row_end) begin
                    // one pixel wide row
                    o_push.valid    = 1'b1;
                    o_push.job.mid  = w_cur;
                    o_push.job.pres = w_cur_pres;
                    o_push.job.last = 1'b1;
                    n_seen          = 2'd0;
                end else begin
                    n_seen = 2'd1;
                end
            end else begin
                o_push.valid         = 1'b1;
                o_push.job.left      = r_older;
                o_push.job.mid       = r_newer;
                o_push.job.right     = w_cur;
                o_push.job.has_left  = r_seen[1];
                o_push.job.has_right = 1'b1;
                o_push.job.pres      = r_pres;
                n_older              = r_newer;
                n_newer              = w_cur;
                n_pres               = w_cur_pres;
                if (i_col.row_end) begin
                    n_pend = 1'b1;
                    n_seen = 2'd0;
                end else begin
                    n_seen = 2'd2;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pres <= '0;
            r_seen <= '0;
            r_pend <= 1'b0;
        end else begin
            r_pres <= n_pres;
            r_seen <= n_seen;
            r_pend <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_older <= n_older;
        r_newer <= n_newer;
    end

endmodule

>>> sv/sem_job_fifo.sv
`timescale 1ns / 1ps
module sem_job_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  sem_pkg::t_push i_push,
    output logic           o_full,
    input  logic           i_pop,
    output sem_pkg::t_head o_head
);
    import sem_pkg::*;

    t_job                 r_mem [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] r_wr, n_wr;
    logic [QPTR_BITS-1:0] r_rd, n_rd;
    logic [QCNT_BITS-1:0] r_cnt, n_cnt;
    logic                 w_wr_en;
    logic                 w_rd_en;

    assign o_full       = (r_cnt == QCNT_BITS'(QUEUE_DEPTH));
    assign o_head.valid = (r_cnt != '0);
    assign o_head.job   = r_mem[r_rd];
    assign w_wr_en      = i_push.valid && !o_full;
    assign w_rd_en      = i_pop && o_head.valid;

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (w_wr_en) begin
            n_wr = (r_wr == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (w_rd_en) begin
            n_rd = (r_rd == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (w_wr_en && !w_rd_en) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!w_wr_en && w_rd_en) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[r_wr] <= i_push.job;
        end
    end

endmodule

>>> sv/sem_back.sv
`timescale 1ns / 1ps
module sem_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  sem_pkg::t_head i_head,
    output logic           o_pop,
    sem_res_if.source      o_res
);
    import sem_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_GRAD = 5'b00010,
        ST_SQR  = 5'b00100,
        ST_ROOT = 5'b01000,
        ST_FIN  = 5'b10000
    } t_state;

    t_state               r_state, n_state;
    t_job                 r_job, n_job;
    logic [STEP_BITS-1:0] r_step, n_step;
    logic [ABS_BITS-1:0]  r_ax [CHANNELS], n_ax [CHANNELS];
    logic [ABS_BITS-1:0]  r_ay [CHANNELS], n_ay [CHANNELS];
    logic [SQ_BITS-1:0]   r_sq [CHANNELS], n_sq [CHANNELS];
    logic [REM_BITS-1:0]  r_rem [CHANNELS], n_rem [CHANNELS];
    logic [ROOT_BITS-1:0] r_root [CHANNELS], n_root [CHANNELS];
    t_pix                 r_mag [CHANNELS], n_mag [CHANNELS];
    logic                 r_row_last, n_row_last;
    logic                 r_valid, n_valid;

    logic signed [GRAD_BITS-1:0] w_e [CHANNELS][ROWS][COLS];
    logic signed [GRAD_BITS-1:0] w_gx [CHANNELS];
    logic signed [GRAD_BITS-1:0] w_gy [CHANNELS];
    logic [2*ABS_BITS-1:0]       w_ax2 [CHANNELS];
    logic [2*ABS_BITS-1:0]       w_ay2 [CHANNELS];
    logic [REM_BITS-1:0]         w_rem_ext [CHANNELS];
    logic [REM_BITS-1:0]         w_trial [CHANNELS];
    logic                        w_up [CHANNELS];
    logic [ROOT_BITS:0]          w_rounded [CHANNELS];
    logic                        w_row_on [ROWS];
    logic                        w_col_on [COLS];
    t_column                     w_col [COLS];

    function automatic logic [ABS_BITS-1:0] f_abs(input logic signed [GRAD_BITS-1:0] v);
        logic signed [GRAD_BITS-1:0] m;
        m = (v < 0) ? -v : v;
        return m[ABS_BITS-1:0];
    endfunction

    assign o_res.valid      = r_valid;
    assign o_res.edge_red   = r_mag[0];
    assign o_res.edge_green = r_mag[1];
    assign o_res.edge_blue  = r_mag[2];
    assign o_res.row_last   = r_row_last;

    assign w_col[0]    = r_job.left;
    assign w_col[1]    = r_job.mid;
    assign w_col[2]    = r_job.right;
    assign w_col_on[0] = r_job.has_left;
    assign w_col_on[1] = 1'b1;
    assign w_col_on[2] = r_job.has_right;
    assign w_row_on[0] = r_job.pres[PRES_TOP];
    assign w_row_on[1] = 1'b1;
    assign w_row_on[2] = r_job.pres[PRES_BOTTOM];

    always_comb begin
        for (int c = 0; c < CHANNELS; c++) begin
            for (int r = 0; r < ROWS; r++) begin
                for (int k = 0; k < COLS; k++) begin
                    w_e[c][r][k] = (w_row_on[r] && w_col_on[k])
                        ? $signed({{(GRAD_BITS-PIXEL_BITS){1'b0}}, w_col[k][r*CHANNELS+c]})
                        : '0;
                end
            end
            w_gx[c] = (w_e[c][0][2] - w_e[c][0][0])
                    + ((w_e[c][1][2] - w_e[c][1][0]) <<< 1)
                    + (w_e[c][2][2] - w_e[c][2][0]);
            w_gy[c] = (w_e[c][2][0] + (w_e[c][2][1] <<< 1) + w_e[c][2][2])
                    - (w_e[c][0][0] + (w_e[c][0][1] <<< 1) + w_e[c][0][2]);
            w_ax2[c]     = r_ax[c] * r_ax[c];
            w_ay2[c]     = r_ay[c] * r_ay[c];
            w_rem_ext[c] = {r_rem[c][REM_BITS-3:0], r_sq[c][SQ_BITS-1 -: 2]};
            w_trial[c]   = {1'b0, r_root[c], 2'b01};
            w_up[c]      = r_rem[c] > {3'b000, r_root[c]};
            w_rounded[c] = {1'b0, r_root[c]} + (ROOT_BITS+1)'(w_up[c]);
        end
    end

    always_comb begin
        n_state    = r_state;
        n_job      = r_job;
        n_step     = r_step;
        n_ax       = r_ax;
        n_ay       = r_ay;
        n_sq       = r_sq;
        n_rem      = r_rem;
        n_root     = r_root;
        n_mag      = r_mag;
        n_row_last = r_row_last;
        n_valid    = r_valid;
        o_pop      = 1'b0;
        if (r_valid && o_res.ready) begin
            n_valid = 1'b0;
        end
        unique case (r_state)
            ST_IDLE: begin
                if (i_head.valid) begin
                    o_pop   = 1'b1;
                    n_job   = i_head.job;
                    n_state = ST_GRAD;
                end
            end
            ST_GRAD: begin
                for (int c = 0; c < CHANNELS; c++) begin
                    n_ax[c] = f_abs(w_gx[c]);
                    n_ay[c] = f_abs(w_gy[c]);
                end
                n_state = ST_SQR;
            end
            ST_SQR: begin
                for (int c = 0; c < CHANNELS; c++) begin
                    n_sq[c]   = SQ_BITS'(w_ax2[c]) + SQ_BITS'(w_ay2[c]);
                    n_rem[c]  = '0;
                    n_root[c] = '0;
                end
                n_step  = '0;
                n_state = ST_ROOT;
            end
            ST_ROOT: begin
                for (int c = 0; c < CHANNELS; c++) begin
                    n_sq[c] = {r_sq[c][SQ_BITS-3:0], 2'b00};
                    if (w_rem_ext[c] >= w_trial[c]) begin
                        n_rem[c]  = w_rem_ext[c] - w_trial[c];
                        n_root[c] = {r_root[c][ROOT_BITS-2:0], 1'b1};
                    end else begin
                        n_rem[c]  = w_rem_ext[c];
                        n_root[c] = {r_root[c][ROOT_BITS-2:0], 1'b0};
                    end
                end
                if (r_step == STEP_BITS'(ROOT_BITS - 1)) begin
                    n_state = ST_FIN;
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            ST_FIN: begin
                if (!r_valid) begin
                    for (int c = 0; c < CHANNELS; c++) begin
                        n_mag[c] = (w_rounded[c] > {{(ROOT_BITS+1-PIXEL_BITS){1'b0}}, PIX_MAX})
                                 ? PIX_MAX : w_rounded[c][PIXEL_BITS-1:0];
                    end
                    n_row_last = r_job.last;
                    n_valid    = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_job      <= n_job;
        r_step     <= n_step;
        r_ax       <= n_ax;
        r_ay       <= n_ay;
        r_sq       <= n_sq;
        r_rem      <= n_rem;
        r_root     <= n_root;
        r_mag      <= n_mag;
        r_row_last <= n_row_last;
    end

endmodule

>>> sv/sobel_edge_magnitude_core.sv
`timescale 1ns / 1ps
// channel  dir  contents
// i_col    in   one column: top, mid, bottom rgb, top_present, bottom_present, row_end
// o_res    out  edge_red, edge_green, edge_blue, row_last for one centre pixel
//
// each result passes through the magnitude unit in these steps:
// queue pop, gradient, squares, one root bit per cycle, rounding and clamp
// the front takes one column per cycle while the two-entry job queue has room;
// a row end that closes two pixels holds the input until its second job is pushed
// reset (synchronous, active low) empties the queue and forgets the held columns
// a stalled output holds its result; the unit loads a new one only into an empty register
module sobel_edge_magnitude_core (
    input  logic      i_clk,
    input  logic      i_rst_n,
    sem_col_if.sink   i_col,
    sem_res_if.source o_res
);
    import sem_pkg::*;

    t_push w_push;
    t_head w_head;
    logic  w_full;
    logic  w_pop;

    sem_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_col   (i_col),
        .i_full  (w_full),
        .o_push  (w_push)
    );

    sem_job_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_head  (w_head)
    );

    sem_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (w_head),
        .o_pop   (w_pop),
        .o_res   (o_res)
    );

endmodule

>>> sv/sem_checker.sv
`timescale 1ns / 1ps
module sem_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_out_valid,
    input logic                          i_out_ready,
    input logic [3*sem_pkg::PIXEL_BITS:0] i_out_data
);
    import sem_pkg::*;

    a_valid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped while stalled");

    a_data_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_out_data))
        else $error("result changed while stalled");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid ##1 !i_out_valid)
        else $error("result shown too soon after reset");

    a_no_back_to_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_ready |=> !i_out_valid)
        else $error("output register reloaded while occupied");

endmodule

bind sobel_edge_magnitude_core sem_checker u_sem_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_out_data  ({o_res.edge_red, o_res.edge_green, o_res.edge_blue, o_res.row_last})
);

>>> bench/sobel_result_check.sv
`timescale 1ns / 1ps
module sobel_result_check (
    input  logic i_clk,
    input  logic i_rst_n,
    sem_col_if   i_col,
    sem_res_if   i_res,
    output int   o_mismatches,
    output int   o_pending
);
    import sem_pkg::*;

    typedef struct packed {
        t_pix red;
        t_pix green;
        t_pix blue;
        logic last;
    } t_edge;

    t_column    older_col;
    t_column    newer_col;
    logic [1:0] newer_pres;
    int         held_cols = 0;
    int         mismatches = 0;
    t_edge      expected_edges[$];

    function automatic t_pix channel_magnitude(int gx, int gy);
        int unsigned sum;
        int unsigned root;
        int unsigned trial;
        sum  = gx * gx + gy * gy;
        root = 0;
        for (int b = 11; b >= 0; b--) begin
            trial = root | (32'd1 << b);
            if (trial * trial <= sum) root = trial;
        end
        if (sum > root * root + root) root++;
        return (root > PIX_MAX) ? PIX_MAX : t_pix'(root);
    endfunction

    function automatic t_edge edge_window(t_column left, t_column mid, t_column right,
                                          logic has_left, logic has_right,
                                          logic [1:0] pres, logic last);
        t_column cols[COLS];
        logic    present[COLS];
        int      gx;
        int      gy;
        int      p;
        t_pix    mag[CHANNELS];
        t_edge   e;
        cols[0]    = left;
        cols[1]    = mid;
        cols[2]    = right;
        present[0] = has_left;
        present[1] = 1'b1;
        present[2] = has_right;
        for (int ch = 0; ch < CHANNELS; ch++) begin
            gx = 0;
            gy = 0;
            for (int row = 0; row < ROWS; row++) begin
                if (row == 0 && !pres[PRES_TOP]) continue;
                if (row == 2 && !pres[PRES_BOTTOM]) continue;
                for (int col = 0; col < COLS; col++) begin
                    if (!present[col]) continue;
                    p  = int'(cols[col][row * CHANNELS + ch]);
                    gx += (col - 1) * ((row == 1) ? 2 : 1) * p;
                    gy += (row - 1) * ((col == 1) ? 2 : 1) * p;
                end
            end
            mag[ch] = channel_magnitude(gx, gy);
        end
        e.red   = mag[0];
        e.green = mag[1];
        e.blue  = mag[2];
        e.last  = last;
        return e;
    endfunction

    task automatic note_mismatch(string what, int want, int got);
        mismatches++;
        $display("%0t: %s expected %0d actual %0d", $time, what, want, got);
    endtask

    always @(posedge i_clk) begin : watch
        t_column    cur;
        logic [1:0] pres;
        t_edge      got;
        t_edge      want;
        if (!i_rst_n) begin
            older_col  = '0;
            newer_col  = '0;
            newer_pres = '0;
            held_cols  = 0;
            expected_edges.delete();
        end else begin
            if (i_col.valid && i_col.ready) begin
                cur[0] = i_col.top_red;
                cur[1] = i_col.top_green;
                cur[2] = i_col.top_blue;
                cur[3] = i_col.mid_red;
                cur[4] = i_col.mid_green;
                cur[5] = i_col.mid_blue;
                cur[6] = i_col.bottom_red;
                cur[7] = i_col.bottom_green;
                cur[8] = i_col.bottom_blue;
                pres   = {i_col.bottom_present, i_col.top_present};
                if (held_cols == 0) begin
                    newer_col  = cur;
                    newer_pres = pres;
                    if (i_col.row_end) begin
                        // one pixel wide row
                        expected_edges.push_back(edge_window('0, cur, '0, 1'b0, 1'b0,
                                                             pres, 1'b1));
                        held_cols = 0;
                    end else begin
                        held_cols = 1;
                    end
                end else begin
                    expected_edges.push_back(edge_window(older_col, newer_col, cur,
                                                         held_cols >= 2, 1'b1,
                                                         newer_pres, 1'b0));
                    older_col  = newer_col;
                    newer_col  = cur;
                    newer_pres = pres;
                    held_cols  = 2;
                    if (i_col.row_end) begin
                        // row end flushes the new column as centre
                        expected_edges.push_back(edge_window(older_col, newer_col, '0,
                                                             1'b1, 1'b0,
                                                             newer_pres, 1'b1));
                        held_cols = 0;
                    end
                end
            end
            if (i_res.valid && i_res.ready) begin
                got = '{i_res.edge_red, i_res.edge_green, i_res.edge_blue, i_res.row_last};
                if (expected_edges.size() == 0) begin
                    mismatches++;
                    $display("%0t: item expected none actual %0d %0d %0d last %0d",
                             $time, got.red, got.green, got.blue, got.last);
                end else begin
                    want = expected_edges.pop_front();
                    if (got.red != want.red) note_mismatch("edge_red", want.red, got.red);
                    if (got.green != want.green)
                        note_mismatch("edge_green", want.green, got.green);
                    if (got.blue != want.blue) note_mismatch("edge_blue", want.blue, got.blue);
                    if (got.last != want.last)
                        note_mismatch("row_last", want.last, got.last);
                end
            end
        end
        o_pending    = expected_edges.size();
        o_mismatches = mismatches;
    end

endmodule

>>> bench/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
    import sem_pkg::*;

    localparam int COLUMN_COUNT = 950;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 60;

    logic i_clk = 1'b0;
    logic i_rst_n;
    int   mismatches;
    int   pending;
    int   sent = 0;
    int   cycles = 0;
    bit   no_gaps = 1'b0;

    sem_col_if col_if ();
    sem_res_if res_if ();

    sobel_edge_magnitude_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_col   (col_if),
        .o_res   (res_if)
    );

    sobel_result_check u_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_col        (col_if),
        .i_res        (res_if),
        .o_mismatches (mismatches),
        .o_pending    (pending)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    always @(posedge i_clk)
        res_if.ready <= no_gaps || ($urandom_range(99) >= 22);

    function automatic t_column fill_col(t_pix top, t_pix mid, t_pix bot);
        t_column c;
        for (int ch = 0; ch < CHANNELS; ch++) begin
            c[ch]                = top;
            c[CHANNELS + ch]     = mid;
            c[2 * CHANNELS + ch] = bot;
        end
        return c;
    endfunction

    function automatic t_pix rand_pix(int style);
        case (style)
            0:       return t_pix'($urandom_range(255));
            1:       return $urandom_range(1) ? PIX_MAX : t_pix'(0);
            default: return t_pix'(112 + $urandom_range(31));
        endcase
    endfunction

    task automatic send_column(input t_column px, input logic tp, input logic bp,
                               input logic re);
        while (!no_gaps && $urandom_range(99) < 22) begin
            col_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        col_if.valid          <= 1'b1;
        col_if.top_red        <= px[0];
        col_if.top_green      <= px[1];
        col_if.top_blue       <= px[2];
        col_if.mid_red        <= px[3];
        col_if.mid_green      <= px[4];
        col_if.mid_blue       <= px[5];
        col_if.bottom_red     <= px[6];
        col_if.bottom_green   <= px[7];
        col_if.bottom_blue    <= px[8];
        col_if.top_present    <= tp;
        col_if.bottom_present <= bp;
        col_if.row_end        <= re;
        do @(posedge i_clk); while (!col_if.ready);
        sent++;
    endtask

    task automatic drain_results();
        col_if.valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    initial begin : stimulus
        t_column px;
        int      width;
        int      style;
        logic    tp;
        logic    bp;
        logic    re;
        bit      mixed;
        i_rst_n               <= 1'b0;
        col_if.valid          <= 1'b0;
        col_if.top_red        <= '0;
        col_if.top_green      <= '0;
        col_if.top_blue       <= '0;
        col_if.mid_red        <= '0;
        col_if.mid_green      <= '0;
        col_if.mid_blue       <= '0;
        col_if.bottom_red     <= '0;
        col_if.bottom_green   <= '0;
        col_if.bottom_blue    <= '0;
        col_if.top_present    <= 1'b0;
        col_if.bottom_present <= 1'b0;
        col_if.row_end        <= 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // one pixel rows
        send_column(fill_col(PIX_MAX, PIX_MAX, PIX_MAX), 1'b1, 1'b1, 1'b1);
        send_column(fill_col(t_pix'(0), PIX_MAX, t_pix'(0)), 1'b0, 1'b1, 1'b1);
        // two pixel row
        send_column(fill_col(t_pix'(0), t_pix'(0), t_pix'(0)), 1'b1, 1'b1, 1'b0);
        send_column(fill_col(PIX_MAX, PIX_MAX, PIX_MAX), 1'b1, 1'b1, 1'b1);
        // horizontal step under every presence combination
        for (int f = 3; f >= 0; f--) begin
            send_column(fill_col(t_pix'(0), t_pix'(0), t_pix'(0)), f[0], f[1], 1'b0);
            send_column(fill_col(t_pix'(128), t_pix'(7), t_pix'(200)), f[0], f[1], 1'b0);
            send_column(fill_col(PIX_MAX, PIX_MAX, PIX_MAX), f[0], f[1], 1'b1);
        end
        // vertical step, then a diagonal corner that saturates
        send_column(fill_col(t_pix'(0), t_pix'(90), PIX_MAX), 1'b1, 1'b1, 1'b0);
        send_column(fill_col(t_pix'(0), t_pix'(90), PIX_MAX), 1'b1, 1'b1, 1'b0);
        send_column(fill_col(PIX_MAX, PIX_MAX, PIX_MAX), 1'b1, 1'b1, 1'b0);
        send_column(fill_col(t_pix'(0), t_pix'(1), t_pix'(3)), 1'b1, 1'b1, 1'b0);
        send_column(fill_col(t_pix'(2), t_pix'(0), t_pix'(5)), 1'b1, 1'b1, 1'b1);
        drain_results();

        while (sent < COLUMN_COUNT) begin
            width   = ($urandom_range(7) == 0) ? $urandom_range(24, 8) : $urandom_range(6, 1);
            style   = $urandom_range(2);
            tp      = $urandom_range(3) != 0;
            bp      = $urandom_range(3) != 0;
            mixed   = $urandom_range(4) == 0;
            no_gaps = (sent >= 400 && sent < 560);
            if ($urandom_range(24) == 0) drain_results();
            for (int c = 0; c < width; c++) begin
                for (int k = 0; k < TAPS; k++) px[k] = rand_pix(style);
                if (mixed) begin
                    tp = 1'($urandom_range(1));
                    bp = 1'($urandom_range(1));
                end
                re = (c == width - 1) || (mixed && $urandom_range(9) == 0);
                send_column(px, tp, bp, re);
            end
        end
        no_gaps = 1'b0;
        drain_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatches == 0 && pending == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

>>> filelist.f
sv/sem_pkg.sv
sv/sem_stream_if.sv
sv/sem_front.sv
sv/sem_job_fifo.sv
sv/sem_back.sv
sv/sobel_edge_magnitude_core.sv
sv/sem_checker.sv
bench/sobel_result_check.sv
bench/tb_top.sv
